// ----- rtl/vbos_pkg.sv -----
`default_nettype none

package vbos_pkg;

	// Field widths of the channel words and the configuration register.
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 12;
	localparam int STATUS_W = 2;
	localparam int OFFSET_W = 32;

	// Coding constants: seven payload bits per byte, bit 7 marks an element's last byte.
	localparam int GROUP_BITS = 7;
	localparam int BYTE_BITS  = 8;
	localparam int STOP_BIT   = 7;

	// Defaults for the top-level parameters.
	localparam int VALUE_BITS_DEF  = 32;
	localparam int STORE_BYTES_DEF = 4096;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BELOW     = 2'd3;

	// Operation codes.
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                capture;
		logic                start_append;
		logic                write_byte;
		logic                start_read;
		logic                scan;
		logic                load_out;
		logic [STATUS_W-1:0] status;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;
		logic below;
		logic full;
		logic bad_index;
		logic last_byte;
		logic scan_done;
	} dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/vbos_in_if.sv -----
`default_nettype none

interface vbos_in_if
	import vbos_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               op;
	logic [VALUE_W-1:0] value;
	logic [INDEX_W-1:0] index;

	modport source (output valid, output op, output value, output index, input ready);
	modport sink (input valid, input op, input value, input index, output ready);
endinterface

`default_nettype wire

// ----- rtl/vbos_out_if.sv -----
`default_nettype none

interface vbos_out_if
	import vbos_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  data;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output data, output status, input ready);
	modport sink (input valid, input data, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/vbos_ctrl.sv -----
`default_nettype none

module vbos_ctrl
	import vbos_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_WRITE = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic [STATUS_W-1:0] st_q;
	logic [STATUS_W-1:0] st_d;
	logic                out_valid_q;
	logic                out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Next state, status code and datapath commands.
	always_comb begin
		state_d          = state_q;
		st_d             = st_q;
		cmd              = '0;
		cmd.status       = st_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.is_read) begin
					if (sts.bad_index) begin
						st_d    = ST_BAD_INDEX;
						state_d = S_DONE;
					end else begin
						st_d           = ST_OK;
						cmd.start_read = 1'b1;
						state_d        = S_SCAN;
					end
				end else if (sts.below) begin
					st_d    = ST_BELOW;
					state_d = S_DONE;
				end else if (sts.full) begin
					st_d    = ST_FULL;
					state_d = S_DONE;
				end else begin
					st_d             = ST_OK;
					cmd.start_append = 1'b1;
					state_d          = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.write_byte = 1'b1;
				if (sts.last_byte) begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, status and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/vbos_dpath.sv -----
`default_nettype none

module vbos_dpath
	import vbos_pkg::*;
#(
	parameter int VALUE_BITS  = VALUE_BITS_DEF,
	parameter int STORE_BYTES = STORE_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [OFFSET_W-1:0] cfg_wdata,
	input  wire logic                op,
	input  wire logic [VALUE_W-1:0]  value,
	input  wire logic [INDEX_W-1:0]  index,
	output logic      [VALUE_W-1:0]  data,
	output logic      [STATUS_W-1:0] status,
	input  wire dp_cmd_t             cmd,
	output dp_sts_t                  sts
);

	localparam int VB  = VALUE_BITS;
	localparam int G   = (VB + GROUP_BITS - 1) / GROUP_BITS;
	localparam int GW  = G * GROUP_BITS;
	localparam int NW  = $clog2(G + 1);
	localparam int KI  = $clog2(G);
	localparam int PW  = $clog2(STORE_BYTES + 1);
	localparam int AW  = $clog2(STORE_BYTES);
	localparam int IXW = (PW > INDEX_W) ? PW : INDEX_W;

	logic [OFFSET_W-1:0]       offset_q;
	logic                      op_q;
	logic [VB-1:0]             value_q;
	logic [INDEX_W-1:0]        index_q;
	logic [PW-1:0]             wp_q;
	logic [PW-1:0]             count_q;
	logic [BYTE_BITS-1:0]      mem [STORE_BYTES];

	logic [VB-1:0]             off_vb;
	logic [VB-1:0]             diff;
	logic [GW-1:0]             dpad;
	logic [NW-1:0]             n_groups;
	logic [PW-1:0]             room;

	logic [GW-1:0]             d_q;
	logic [NW-1:0]             n_q;
	logic [NW-1:0]             bcnt_q;
	logic                      last_byte;

	logic [PW-1:0]             raddr_q;
	logic                      rd_en;
	logic [BYTE_BITS-1:0]      rdata_s1;
	logic [PW-1:0]             pos_s1;
	logic                      rvalid_s1;
	logic [INDEX_W-1:0]        seen_q;
	logic [NW-1:0]             k_q;
	logic [GROUP_BITS-1:0]     grp_q [G];
	logic                      in_skip;
	logic                      past_end;
	logic                      consume;
	logic [GW-1:0]             acc;
	logic [VB-1:0]             result;
	logic [VALUE_W-1:0]        data_q;
	logic [STATUS_W-1:0]       status_q;

	assign off_vb = VB'(offset_q);
	assign diff   = value_q - off_vb;
	assign dpad   = GW'(diff);
	assign room   = PW'(STORE_BYTES) - wp_q;

	// Number of bytes the difference needs: one past the highest nonzero group.
	always_comb begin
		n_groups = NW'(1);
		for (int g = 1; g < G; g++) begin
			if (dpad[g*GROUP_BITS +: GROUP_BITS] != '0) begin
				n_groups = NW'(g + 1);
			end
		end
	end

	assign last_byte = (bcnt_q == n_q - NW'(1));

	// Scan side: bytes arrive in the cycle after their address is issued.
	assign rd_en    = cmd.scan && (raddr_q < wp_q);
	assign in_skip  = (seen_q != index_q);
	assign past_end = (pos_s1 >= wp_q);
	assign consume  = cmd.scan && rvalid_s1 && !past_end;

	always_comb begin
		for (int g = 0; g < G; g++) begin
			acc[g*GROUP_BITS +: GROUP_BITS] = grp_q[g];
		end
	end

	assign result = VB'(acc) + off_vb;

	// Result word registers drive the output channel.
	assign data   = data_q;
	assign status = status_q;

	// Status toward the controller.
	always_comb begin
		sts           = '0;
		sts.is_read   = (op_q == OP_READ);
		sts.below     = (value_q < off_vb);
		sts.full      = (PW'(n_groups) > room);
		sts.bad_index = (IXW'(index_q) >= IXW'(count_q));
		sts.last_byte = last_byte;
		sts.scan_done = cmd.scan && rvalid_s1 &&
			(past_end || (!in_skip && rdata_s1[STOP_BIT]));
	end

	// Configuration register and store bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= '0;
			wp_q      <= '0;
			count_q   <= '0;
			bcnt_q    <= '0;
			raddr_q   <= '0;
			rvalid_s1 <= 1'b0;
			seen_q    <= '0;
			k_q       <= '0;
		end else begin
			if (cfg_we) begin
				offset_q <= cfg_wdata;
			end
			if (cmd.start_append) begin
				bcnt_q <= '0;
			end else if (cmd.write_byte) begin
				bcnt_q <= bcnt_q + NW'(1);
				wp_q   <= wp_q + PW'(1);
				if (last_byte) begin
					count_q <= count_q + PW'(1);
				end
			end
			rvalid_s1 <= cmd.scan;
			if (cmd.start_read) begin
				raddr_q <= '0;
				seen_q  <= '0;
				k_q     <= '0;
			end else begin
				if (rd_en) begin
					raddr_q <= raddr_q + PW'(1);
				end
				if (consume) begin
					if (in_skip) begin
						if (rdata_s1[STOP_BIT]) begin
							seen_q <= seen_q + INDEX_W'(1);
						end
					end else if (k_q < NW'(G)) begin
						k_q <= k_q + NW'(1);
					end
				end
			end
		end
	end

	// Captured item, encoder shift register and assembled groups.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			value_q <= VB'(value);
			index_q <= index;
		end
		if (cmd.start_append) begin
			d_q <= dpad;
			n_q <= n_groups;
		end else if (cmd.write_byte) begin
			d_q <= d_q >> GROUP_BITS;
		end
		if (cmd.start_read) begin
			for (int g = 0; g < G; g++) begin
				grp_q[g] <= '0;
			end
		end else if (consume && !in_skip && (k_q < NW'(G))) begin
			grp_q[k_q[KI-1:0]] <= rdata_s1[GROUP_BITS-1:0];
		end
		if (cmd.load_out) begin
			status_q <= cmd.status;
			if ((cmd.status == ST_OK) && (op_q == OP_READ)) begin
				data_q <= VALUE_W'(result);
			end else begin
				data_q <= '0;
			end
		end
	end

	// Byte memory: one write port for appends, one registered read port for scans.
	always_ff @(posedge clk) begin
		if (cmd.write_byte) begin
			mem[wp_q[AW-1:0]] <= {last_byte, d_q[GROUP_BITS-1:0]};
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr_q[AW-1:0]];
		end
		pos_s1 <= raddr_q;
	end

endmodule

`default_nettype wire

// ----- rtl/vbyte_offset_store.sv -----
`default_nettype none

// Variable-byte integer store. An append subtracts the base offset from the
// word's value and writes the difference as 7-bit groups, least significant
// first, one byte each, with bit 7 set on the last byte; a read walks the
// byte memory from address zero, counting last-byte marks up to the requested
// index, then reassembles that element and adds the base offset back. Every
// input word yields exactly one result word. An append writes n bytes, where
// n is the byte count of the element (one up to ceil(VALUE_BITS / 7)), one
// after another, since the single memory write port takes one byte per cycle.
// A read walks every stored byte up to and including the last byte of the
// requested element, since the scan moves one byte per cycle through the
// registered memory read port. Errors (value below offset, store full, index
// out of range) return a status code without writing or scanning the memory.
// The result register lets a new word be accepted while a result still waits.
// The base offset register must only be written while the block is idle.
module vbyte_offset_store
	import vbos_pkg::*;
#(
	parameter int VALUE_BITS  = VALUE_BITS_DEF,
	parameter int STORE_BYTES = STORE_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [OFFSET_W-1:0] cfg_wdata,
	vbos_in_if.sink                  in_chan,
	vbos_out_if.source               out_chan
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer for check, byte writes, scan and result handoff.
	vbos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_chan.valid),
		.in_ready  (in_chan.ready),
		.out_valid (out_chan.valid),
		.out_ready (out_chan.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Offset register, byte memory, encoder and decoder.
	vbos_dpath #(
		.VALUE_BITS  (VALUE_BITS),
		.STORE_BYTES (STORE_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op        (in_chan.op),
		.value     (in_chan.value),
		.index     (in_chan.index),
		.data      (out_chan.data),
		.status    (out_chan.status),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire
